FILE: design/kmce_pkg.sv
package kmce_pkg;

    localparam int NUM_DIMS   = 4;
    localparam int NUM_CLUST  = 3;
    localparam int COORD_W    = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * COORD_W + 1;
    localparam int DIST_W     = SQ_W + 2;
    localparam int CID_W      = 2;
    localparam int DIM_IW     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int INIT_W     = 8;
    localparam int PASS_W     = 16;
    localparam int COUNT_W    = 9;
    localparam int DRAIN_W    = 3;
    // Drain count after the walk; covers the lane and merge pipeline with margin
    localparam int PIPE_DRAIN = 6;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [NUM_DIMS-1:0][COORD_W-1:0] point_t;
    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [CID_W-1:0] cid_t;
    typedef logic [DIM_IW-1:0] dim_idx_t;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_RUN   = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INIT0 = 2'd0,
        CFG_INIT1 = 2'd1,
        CFG_INIT2 = 2'd2,
        CFG_LIMIT = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_PASS,
        ST_DRAIN,
        ST_DIVIDE,
        ST_CHECK,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic valid;
        logic clear;
    } merge_ctl_t;

endpackage

FILE: design/kmce_ram.sv
module kmce_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/kmce_lane.sv
module kmce_lane (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  kmce_pkg::point_t  point,
    input  kmce_pkg::point_t  center,
    output logic              out_valid,
    output kmce_pkg::dist_t   distance
);

    logic signed [kmce_pkg::DIFF_W-1:0]   diff [kmce_pkg::NUM_DIMS];
    logic signed [2*kmce_pkg::DIFF_W-1:0] prod [kmce_pkg::NUM_DIMS];
    logic [kmce_pkg::SQ_W-1:0]            sq_next [kmce_pkg::NUM_DIMS];
    logic [kmce_pkg::SQ_W-1:0]            sq_reg [kmce_pkg::NUM_DIMS];
    logic                                 sq_valid_reg;
    kmce_pkg::dist_t                      dist_next;
    kmce_pkg::dist_t                      dist_reg;
    logic                                 out_valid_reg;

    // Square each coordinate difference
    always_comb
    begin
        for (int d = 0; d < kmce_pkg::NUM_DIMS; d++)
        begin
            diff[d] = kmce_pkg::DIFF_W'($signed(point[d]))
                    - kmce_pkg::DIFF_W'($signed(center[d]));
            prod[d] = diff[d] * diff[d];
            sq_next[d] = prod[d][kmce_pkg::SQ_W-1:0];
        end
    end

    // Add the squares
    always_comb
    begin
        dist_next = '0;
        for (int d = 0; d < kmce_pkg::NUM_DIMS; d++)
        begin
            dist_next = dist_next + kmce_pkg::DIST_W'(sq_reg[d]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sq_valid_reg  <= in_valid;
            out_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg   <= sq_next;
        dist_reg <= dist_next;
    end

    assign out_valid = out_valid_reg;
    assign distance  = dist_reg;

endmodule

FILE: design/kmce_merge.sv
module kmce_merge #(
    parameter int AW    = 8,
    parameter int CW    = 9,
    parameter int SUM_W = 25
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  kmce_pkg::merge_ctl_t    ctl,
    input  kmce_pkg::dist_t         dists [kmce_pkg::NUM_CLUST],
    input  kmce_pkg::point_t        point,
    input  logic [AW-1:0]           idx,
    output logic                    asg_we,
    output logic [AW-1:0]           asg_addr,
    output kmce_pkg::cid_t          asg_data,
    output logic signed [SUM_W-1:0] sums [kmce_pkg::NUM_CLUST][kmce_pkg::NUM_DIMS],
    output logic [CW-1:0]           counts [kmce_pkg::NUM_CLUST]
);

    kmce_pkg::cid_t          best_next;
    kmce_pkg::dist_t         bestd;
    kmce_pkg::cid_t          best_reg;
    logic                    a_valid_reg;
    kmce_pkg::point_t        pt_reg;
    logic [AW-1:0]           idx_reg;
    logic signed [SUM_W-1:0] sum_reg [kmce_pkg::NUM_CLUST][kmce_pkg::NUM_DIMS];
    logic [CW-1:0]           count_reg [kmce_pkg::NUM_CLUST];

    // Nearest center, lowest index on a tie
    always_comb
    begin
        best_next = '0;
        bestd     = dists[0];
        for (int k = 1; k < kmce_pkg::NUM_CLUST; k++)
        begin
            if (dists[k] < bestd)
            begin
                bestd     = dists[k];
                best_next = kmce_pkg::CID_W'(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            for (int k = 0; k < kmce_pkg::NUM_CLUST; k++)
            begin
                count_reg[k] <= '0;
                for (int d = 0; d < kmce_pkg::NUM_DIMS; d++)
                begin
                    sum_reg[k][d] <= '0;
                end
            end
        end
        else
        begin
            a_valid_reg <= ctl.valid;
            if (ctl.clear)
            begin
                for (int k = 0; k < kmce_pkg::NUM_CLUST; k++)
                begin
                    count_reg[k] <= '0;
                    for (int d = 0; d < kmce_pkg::NUM_DIMS; d++)
                    begin
                        sum_reg[k][d] <= '0;
                    end
                end
            end
            else if (a_valid_reg)
            begin
                count_reg[best_reg] <= count_reg[best_reg] + CW'(1);
                for (int d = 0; d < kmce_pkg::NUM_DIMS; d++)
                begin
                    sum_reg[best_reg][d] <= sum_reg[best_reg][d]
                                          + SUM_W'($signed(pt_reg[d]));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        pt_reg   <= point;
        idx_reg  <= idx;
    end

    assign asg_we   = a_valid_reg;
    assign asg_addr = idx_reg;
    assign asg_data = best_reg;
    assign sums     = sum_reg;
    assign counts   = count_reg;

endmodule

FILE: design/kmce_div.sv
module kmce_div #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 9
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    done,
    output kmce_pkg::coord_t        quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NUM_W-1:0]  mag_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W:0]    rem_reg;
    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    rem_next;
    logic              qbit;
    logic [NUM_W-1:0]  quo_signed;

    // One quotient bit per cycle, restoring
    always_comb
    begin
        rem_sh = {rem_reg[DEN_W-1:0], mag_reg[NUM_W-1]};
        qbit   = (rem_sh >= {1'b0, den_reg});
        rem_next = qbit ? (rem_sh - {1'b0, den_reg}) : rem_sh;
        quo_signed = neg_reg ? (NUM_W'(0) - quo_reg) : quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_W-1];
            mag_reg <= num[NUM_W-1] ? (NUM_W'(0) - num) : num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            mag_reg <= {mag_reg[NUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], qbit};
        end
    end

    assign done = done_reg;
    assign quo  = quo_signed[kmce_pkg::COORD_W-1:0];

endmodule

FILE: design/kmeans_cluster_engine_core.sv
// Channel   Direction  Handshake             Transaction
// in        input      in_valid / in_stall   one command with point and query index
// out       output     out_valid / out_stall one cluster result or assignment readback
// cfg       input      cfg_valid / cfg_ready register index and write data
//
// A query result is read from the assignment RAM. A run lasts longer with more passes,
// more points and output stalls; its length is set by the single point RAM read port
// and the shared serial divider.
// Reset (rst_n, asynchronous, active low) empties the store; no clearing pass is needed.
// in_stall rises while a run or query is in flight or a result waits under out_stall.
module kmeans_cluster_engine_core #(
    parameter int MAX_POINTS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic signed [15:0] coord_a,
    input  logic signed [15:0] coord_b,
    input  logic signed [15:0] coord_c,
    input  logic signed [15:0] coord_d,
    input  logic [7:0]  query_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  cluster_id,
    output logic [8:0]  member_count,
    output logic signed [15:0] center_a,
    output logic signed [15:0] center_b,
    output logic signed [15:0] center_c,
    output logic signed [15:0] center_d,
    output logic [15:0] passes_used,
    output logic        converged,
    output logic        last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int SUM_W = kmce_pkg::COORD_W + $clog2(MAX_POINTS) + 1;
    localparam int KC_W  = $clog2(kmce_pkg::NUM_CLUST + 1);
    localparam int PT_W  = kmce_pkg::NUM_DIMS * kmce_pkg::COORD_W;

    kmce_pkg::state_t state_reg, state_next;

    // Configuration registers
    logic [kmce_pkg::INIT_W-1:0] init_reg [kmce_pkg::NUM_CLUST];
    logic [kmce_pkg::PASS_W-1:0] limit_reg;
    logic [kmce_pkg::PASS_W-1:0] limit_eff;

    // Store bookkeeping
    logic [CW-1:0] pc_reg;
    logic [CW-1:0] asg_cnt_reg;   // entries below this were written since the last clear

    // Run control
    logic [KC_W-1:0]             kc_reg;
    logic                        init_ok_reg;
    logic [CW-1:0]               walk_reg;
    logic                        rd_valid_reg;
    logic [AW-1:0]               rd_idx_reg;
    logic [AW-1:0]               idx_d1_reg, idx_d2_reg;
    kmce_pkg::point_t            pt_d1_reg, pt_d2_reg;
    logic [kmce_pkg::DRAIN_W-1:0] drain_reg;
    kmce_pkg::cid_t              dk_reg;
    kmce_pkg::dim_idx_t          dd_reg;
    logic                        div_wait_reg;
    logic                        changed_reg;
    logic [kmce_pkg::PASS_W-1:0] pass_reg;
    kmce_pkg::cid_t              oc_reg;
    kmce_pkg::point_t            center_reg [kmce_pkg::NUM_CLUST];

    // Query
    logic q_pend_reg;
    logic q_ok_reg;

    // Output register
    logic                        out_valid_reg;
    kmce_pkg::cid_t              cid_reg;
    logic [kmce_pkg::COUNT_W-1:0] cnt_out_reg;
    kmce_pkg::point_t            cen_out_reg;
    logic [kmce_pkg::PASS_W-1:0] pass_out_reg;
    logic                        conv_out_reg;
    logic                        last_out_reg;

    // Datapath wiring
    logic                        in_acc;
    kmce_pkg::cmd_t              cmd_in;
    logic                        out_free;
    logic                        pt_we;
    logic [AW-1:0]               pt_raddr;
    logic [PT_W-1:0]             pt_rdata;
    kmce_pkg::point_t            pt_word;
    logic [kmce_pkg::INIT_W-1:0] init_sel;
    logic                        lane_valid [kmce_pkg::NUM_CLUST];
    kmce_pkg::dist_t             lane_dist [kmce_pkg::NUM_CLUST];
    kmce_pkg::merge_ctl_t        mctl;
    logic                        pass_start;
    logic                        asg_we;
    logic [AW-1:0]               asg_waddr;
    kmce_pkg::cid_t              asg_wdata;
    kmce_pkg::cid_t              asg_rdata;
    logic signed [SUM_W-1:0]     sums [kmce_pkg::NUM_CLUST][kmce_pkg::NUM_DIMS];
    logic [CW-1:0]               counts [kmce_pkg::NUM_CLUST];
    logic                        div_start;
    logic                        div_done;
    kmce_pkg::coord_t            div_quo;
    logic                        div_last;

    assign cmd_in    = kmce_pkg::cmd_t'(cmd);
    assign in_stall  = (state_reg != kmce_pkg::ST_IDLE) || q_pend_reg
                     || (out_valid_reg && out_stall);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign limit_eff = (limit_reg == '0) ? kmce_pkg::PASS_W'(1) : limit_reg;
    assign pt_we     = in_acc && (cmd_in == kmce_pkg::CMD_LOAD)
                     && (pc_reg < CW'(MAX_POINTS));
    assign init_sel  = (kc_reg < KC_W'(kmce_pkg::NUM_CLUST))
                     ? init_reg[kmce_pkg::CID_W'(kc_reg)] : '0;
    assign pt_raddr  = (state_reg == kmce_pkg::ST_INIT) ? AW'(init_sel) : walk_reg[AW-1:0];
    assign pt_word   = pt_rdata;
    assign div_last  = (dd_reg == kmce_pkg::DIM_IW'(kmce_pkg::NUM_DIMS - 1))
                     && (dk_reg == kmce_pkg::CID_W'(kmce_pkg::NUM_CLUST - 1));

    // Point store: one write port for loads, one read port shared by init and passes
    kmce_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_pt_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pc_reg[AW-1:0]),
        .wdata ({coord_d, coord_c, coord_b, coord_a}),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    // Assignment store: written by the merge stage, read by queries
    kmce_ram #(
        .WIDTH (kmce_pkg::CID_W),
        .DEPTH (MAX_POINTS)
    ) u_asg_ram (
        .clk   (clk),
        .we    (asg_we),
        .waddr (asg_waddr),
        .wdata (asg_wdata),
        .raddr (AW'(query_index)),
        .rdata (asg_rdata)
    );

    // One distance lane per cluster
    for (genvar k = 0; k < kmce_pkg::NUM_CLUST; k++)
    begin : g_lane
        kmce_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (rd_valid_reg),
            .point     (pt_word),
            .center    (center_reg[k]),
            .out_valid (lane_valid[k]),
            .distance  (lane_dist[k])
        );
    end

    assign mctl.valid = lane_valid[0];
    assign mctl.clear = pass_start;

    kmce_merge #(
        .AW    (AW),
        .CW    (CW),
        .SUM_W (SUM_W)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mctl),
        .dists    (lane_dist),
        .point    (pt_d2_reg),
        .idx      (idx_d2_reg),
        .asg_we   (asg_we),
        .asg_addr (asg_waddr),
        .asg_data (asg_wdata),
        .sums     (sums),
        .counts   (counts)
    );

    kmce_div #(
        .NUM_W (SUM_W),
        .DEN_W (CW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sums[dk_reg][dd_reg]),
        .den   (counts[dk_reg]),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Next state and per-state strobes
    always_comb
    begin
        state_next = state_reg;
        pass_start = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            kmce_pkg::ST_IDLE:
            begin
                if (in_acc && (cmd_in == kmce_pkg::CMD_RUN))
                begin
                    state_next = kmce_pkg::ST_INIT;
                end
            end
            kmce_pkg::ST_INIT:
            begin
                if (kc_reg == KC_W'(kmce_pkg::NUM_CLUST))
                begin
                    pass_start = 1'b1;
                    state_next = kmce_pkg::ST_PASS;
                end
            end
            kmce_pkg::ST_PASS:
            begin
                if (walk_reg == pc_reg)
                begin
                    state_next = kmce_pkg::ST_DRAIN;
                end
            end
            kmce_pkg::ST_DRAIN:
            begin
                if (drain_reg == kmce_pkg::DRAIN_W'(kmce_pkg::PIPE_DRAIN))
                begin
                    state_next = kmce_pkg::ST_DIVIDE;
                end
            end
            kmce_pkg::ST_DIVIDE:
            begin
                if (!div_wait_reg)
                begin
                    if (counts[dk_reg] != '0)
                    begin
                        div_start = 1'b1;
                    end
                    else if (div_last)
                    begin
                        state_next = kmce_pkg::ST_CHECK;
                    end
                end
                else if (div_done && div_last)
                begin
                    state_next = kmce_pkg::ST_CHECK;
                end
            end
            kmce_pkg::ST_CHECK:
            begin
                if (changed_reg && (pass_reg < limit_eff))
                begin
                    pass_start = 1'b1;
                    state_next = kmce_pkg::ST_PASS;
                end
                else
                begin
                    state_next = kmce_pkg::ST_OUTPUT;
                end
            end
            kmce_pkg::ST_OUTPUT:
            begin
                if (out_free && !q_pend_reg
                    && (oc_reg == kmce_pkg::CID_W'(kmce_pkg::NUM_CLUST - 1)))
                begin
                    state_next = kmce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kmce_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kmce_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg[0]   <= kmce_pkg::INIT_W'(0);
            init_reg[1]   <= kmce_pkg::INIT_W'(1);
            init_reg[2]   <= kmce_pkg::INIT_W'(2);
            limit_reg     <= kmce_pkg::PASS_W'(100);
            pc_reg        <= '0;
            asg_cnt_reg   <= '0;
            kc_reg        <= '0;
            walk_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            drain_reg     <= '0;
            dk_reg        <= '0;
            dd_reg        <= '0;
            div_wait_reg  <= 1'b0;
            changed_reg   <= 1'b0;
            pass_reg      <= '0;
            oc_reg        <= '0;
            q_pend_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (kmce_pkg::cfg_idx_t'(cfg_index))
                    kmce_pkg::CFG_INIT0: init_reg[0] <= cfg_data[kmce_pkg::INIT_W-1:0];
                    kmce_pkg::CFG_INIT1: init_reg[1] <= cfg_data[kmce_pkg::INIT_W-1:0];
                    kmce_pkg::CFG_INIT2: init_reg[2] <= cfg_data[kmce_pkg::INIT_W-1:0];
                    kmce_pkg::CFG_LIMIT: limit_reg   <= cfg_data;
                    default: ;
                endcase
            end

            // Drop the result once taken; a new load below overrides
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            q_pend_reg   <= 1'b0;
            rd_valid_reg <= 1'b0;

            if (in_acc)
            begin
                case (cmd_in)
                    kmce_pkg::CMD_CLEAR:
                    begin
                        pc_reg      <= '0;
                        asg_cnt_reg <= '0;
                    end
                    kmce_pkg::CMD_LOAD:
                    begin
                        if (pc_reg < CW'(MAX_POINTS))
                        begin
                            pc_reg <= pc_reg + CW'(1);
                        end
                    end
                    kmce_pkg::CMD_RUN:
                    begin
                        // Every stored point gets an assignment during the run
                        asg_cnt_reg <= pc_reg;
                        kc_reg      <= '0;
                        pass_reg    <= '0;
                    end
                    kmce_pkg::CMD_QUERY:
                    begin
                        q_pend_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end

            if (q_pend_reg)
            begin
                out_valid_reg <= 1'b1;
            end

            if (state_reg == kmce_pkg::ST_INIT)
            begin
                kc_reg <= kc_reg + KC_W'(1);
            end

            if (pass_start)
            begin
                walk_reg    <= '0;
                changed_reg <= 1'b0;
                pass_reg    <= pass_reg + kmce_pkg::PASS_W'(1);
            end

            if ((state_reg == kmce_pkg::ST_PASS) && (walk_reg != pc_reg))
            begin
                rd_valid_reg <= 1'b1;
                walk_reg     <= walk_reg + CW'(1);
            end

            if (state_reg == kmce_pkg::ST_PASS)
            begin
                drain_reg <= '0;
                dk_reg    <= '0;
                dd_reg    <= '0;
            end
            else if (state_reg == kmce_pkg::ST_DRAIN)
            begin
                drain_reg <= drain_reg + kmce_pkg::DRAIN_W'(1);
            end

            if (state_reg == kmce_pkg::ST_DIVIDE)
            begin
                if (div_start)
                begin
                    div_wait_reg <= 1'b1;
                end
                if ((!div_wait_reg && !div_start) || (div_wait_reg && div_done))
                begin
                    div_wait_reg <= 1'b0;
                    if (div_wait_reg && (div_quo != $signed(center_reg[dk_reg][dd_reg])))
                    begin
                        changed_reg <= 1'b1;
                    end
                    // Advance to the next coordinate
                    if (dd_reg == kmce_pkg::DIM_IW'(kmce_pkg::NUM_DIMS - 1))
                    begin
                        dd_reg <= '0;
                        if (!div_last)
                        begin
                            dk_reg <= dk_reg + kmce_pkg::CID_W'(1);
                        end
                    end
                    else
                    begin
                        dd_reg <= dd_reg + kmce_pkg::DIM_IW'(1);
                    end
                end
            end

            if (state_reg == kmce_pkg::ST_CHECK)
            begin
                oc_reg <= '0;
            end

            if ((state_reg == kmce_pkg::ST_OUTPUT) && out_free && !q_pend_reg)
            begin
                out_valid_reg <= 1'b1;
                oc_reg        <= oc_reg + kmce_pkg::CID_W'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            q_ok_reg <= (kmce_pkg::PASS_W'(query_index) < kmce_pkg::PASS_W'(asg_cnt_reg));
        end

        // Pipeline alignment between RAM data, lane results and merge stage
        rd_idx_reg <= walk_reg[AW-1:0];
        idx_d1_reg <= rd_idx_reg;
        idx_d2_reg <= idx_d1_reg;
        pt_d1_reg  <= pt_word;
        pt_d2_reg  <= pt_d1_reg;

        if (state_reg == kmce_pkg::ST_INIT)
        begin
            init_ok_reg <= (kmce_pkg::PASS_W'(init_sel) < kmce_pkg::PASS_W'(pc_reg));
            if (kc_reg != '0)
            begin
                center_reg[kmce_pkg::CID_W'(kc_reg - KC_W'(1))] <= init_ok_reg ? pt_word : '0;
            end
        end

        if ((state_reg == kmce_pkg::ST_DIVIDE) && div_wait_reg && div_done)
        begin
            center_reg[dk_reg][dd_reg] <= div_quo;
        end

        if (q_pend_reg)
        begin
            cid_reg      <= q_ok_reg ? asg_rdata : '0;
            cnt_out_reg  <= '0;
            cen_out_reg  <= '0;
            pass_out_reg <= '0;
            conv_out_reg <= 1'b0;
            last_out_reg <= 1'b1;
        end
        else if ((state_reg == kmce_pkg::ST_OUTPUT) && out_free)
        begin
            cid_reg      <= oc_reg;
            cnt_out_reg  <= kmce_pkg::COUNT_W'(counts[oc_reg]);
            cen_out_reg  <= center_reg[oc_reg];
            pass_out_reg <= pass_reg;
            conv_out_reg <= !changed_reg;
            last_out_reg <= (oc_reg == kmce_pkg::CID_W'(kmce_pkg::NUM_CLUST - 1));
        end
    end

    assign out_valid    = out_valid_reg;
    assign cluster_id   = cid_reg;
    assign member_count = cnt_out_reg;
    assign center_a     = cen_out_reg[0];
    assign center_b     = cen_out_reg[1];
    assign center_c     = cen_out_reg[2];
    assign center_d     = cen_out_reg[3];
    assign passes_used  = pass_out_reg;
    assign converged    = conv_out_reg;
    assign last_of_run  = last_out_reg;

endmodule

FILE: design/kmce_checker.sv
module kmce_props (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  cmd,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  cluster_id,
    input logic [8:0]  member_count,
    input logic [15:0] passes_used,
    input logic        last_of_run
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped under stall");

    // A result that is not marked last never carries the final cluster
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> cluster_id != 2'd2 && cluster_id != 2'd3)
        else $error("non-final result carries final cluster");

    // A readback reports no pass count and no members
    a_query: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && passes_used == 16'd0 |-> member_count == 9'd0 && last_of_run)
        else $error("readback carries run fields");

    // A run holds off the input channel
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && cmd == kmce_pkg::CMD_RUN |=> in_stall)
        else $error("input accepted right after run start");

endmodule

bind kmeans_cluster_engine_core kmce_props u_kmce_props (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cluster_id   (cluster_id),
    .member_count (member_count),
    .passes_used  (passes_used),
    .last_of_run  (last_of_run)
);

FILE: tb/kmce_checker.sv
module kmce_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic signed [15:0] coord_a,
    input  logic signed [15:0] coord_b,
    input  logic signed [15:0] coord_c,
    input  logic signed [15:0] coord_d,
    input  logic [7:0]         query_index,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [1:0]         cluster_id,
    input  logic [8:0]         member_count,
    input  logic signed [15:0] center_a,
    input  logic signed [15:0] center_b,
    input  logic signed [15:0] center_c,
    input  logic signed [15:0] center_d,
    input  logic [15:0]        passes_used,
    input  logic               converged,
    input  logic               last_of_run,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 fail_count,
    output int                 pending,
    output int                 runs_done,
    output int                 queries_done,
    output int                 unconverged_runs
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 256;

    typedef struct {
        logic [1:0]         cid;
        logic [8:0]         members;
        logic signed [15:0] ctr [kmce_pkg::NUM_DIMS];
        logic [15:0]        passes;
        logic               conv;
        logic               last;
    } cluster_result_t;

    cluster_result_t    result_fifo[$];

    logic signed [15:0] pts [STORE_DEPTH][kmce_pkg::NUM_DIMS];
    int                 npts;
    logic [1:0]         owner [STORE_DEPTH];
    longint             ctrs [kmce_pkg::NUM_CLUST][kmce_pkg::NUM_DIMS];
    int                 members [kmce_pkg::NUM_CLUST];
    int                 seed_idx [kmce_pkg::NUM_CLUST];
    int                 pass_limit;

    function automatic longint dist2(int p, int k);
        longint acc;
        longint diff;
        acc = 0;
        for (int d = 0; d < kmce_pkg::NUM_DIMS; d++)
        begin
            diff = longint'(pts[p][d]) - ctrs[k][d];
            acc += diff * diff;
        end
        return acc;
    endfunction

    // One assign-and-update sweep; returns 1 if any center moved.
    function automatic bit lloyd_sweep();
        longint sums [kmce_pkg::NUM_CLUST][kmce_pkg::NUM_DIMS];
        longint best_d;
        longint dd;
        longint m;
        int     best;
        bit     moved;
        moved = 0;
        for (int k = 0; k < kmce_pkg::NUM_CLUST; k++)
        begin
            members[k] = 0;
            for (int d = 0; d < kmce_pkg::NUM_DIMS; d++)
                sums[k][d] = 0;
        end
        for (int i = 0; i < npts; i++)
        begin
            best = 0;
            best_d = dist2(i, 0);
            for (int k = 1; k < kmce_pkg::NUM_CLUST; k++)
            begin
                dd = dist2(i, k);
                if (dd < best_d)
                begin
                    best_d = dd;
                    best = k;
                end
            end
            owner[i] = best[1:0];
            members[best]++;
            for (int d = 0; d < kmce_pkg::NUM_DIMS; d++)
                sums[best][d] += pts[i][d];
        end
        for (int k = 0; k < kmce_pkg::NUM_CLUST; k++)
        begin
            if (members[k] != 0)
            begin
                for (int d = 0; d < kmce_pkg::NUM_DIMS; d++)
                begin
                    m = sums[k][d] / longint'(members[k]);
                    if (m != ctrs[k][d])
                        moved = 1;
                    ctrs[k][d] = m;
                end
            end
        end
        return moved;
    endfunction

    task automatic predict_run();
        int              limit;
        int              npass;
        bit              moved;
        cluster_result_t r;
        limit = (pass_limit == 0) ? 1 : pass_limit;
        for (int k = 0; k < kmce_pkg::NUM_CLUST; k++)
            for (int d = 0; d < kmce_pkg::NUM_DIMS; d++)
                ctrs[k][d] = (seed_idx[k] < npts) ? longint'(pts[seed_idx[k]][d]) : 0;
        npass = 0;
        do
        begin
            npass++;
            moved = lloyd_sweep();
        end while (moved && npass < limit);
        for (int k = 0; k < kmce_pkg::NUM_CLUST; k++)
        begin
            r.cid = k[1:0];
            r.members = members[k][8:0];
            for (int d = 0; d < kmce_pkg::NUM_DIMS; d++)
                r.ctr[d] = ctrs[k][d][15:0];
            r.passes = npass[15:0];
            r.conv = !moved;
            r.last = (k == kmce_pkg::NUM_CLUST - 1);
            result_fifo.push_back(r);
        end
        runs_done++;
        if (moved)
            unconverged_runs++;
    endtask

    task automatic mismatch(string what, longint exp_v, longint act_v);
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_v, act_v);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cluster_result_t r;
        if (!rst_n)
        begin
            result_fifo.delete();
            npts = 0;
            for (int i = 0; i < STORE_DEPTH; i++)
                owner[i] = '0;
            seed_idx[0] = 0;
            seed_idx[1] = 1;
            seed_idx[2] = 2;
            pass_limit = 100;
            fail_count = 0;
            pending = 0;
            runs_done = 0;
            queries_done = 0;
            unconverged_runs = 0;
        end
        else
        begin
            // Compare the outgoing transaction first; a new run cannot emit in the same edge.
            if (out_valid && !out_stall)
            begin
                if (result_fifo.size() == 0)
                begin
                    $display("%0t: unexpected result, cluster_id %0d", $time, cluster_id);
                    fail_count++;
                end
                else
                begin
                    r = result_fifo.pop_front();
                    if (cluster_id !== r.cid)        mismatch("cluster_id", r.cid, cluster_id);
                    if (member_count !== r.members)  mismatch("member_count", r.members,
                                                               member_count);
                    if (center_a !== r.ctr[0])       mismatch("center_a", r.ctr[0], center_a);
                    if (center_b !== r.ctr[1])       mismatch("center_b", r.ctr[1], center_b);
                    if (center_c !== r.ctr[2])       mismatch("center_c", r.ctr[2], center_c);
                    if (center_d !== r.ctr[3])       mismatch("center_d", r.ctr[3], center_d);
                    if (passes_used !== r.passes)    mismatch("passes_used", r.passes,
                                                               passes_used);
                    if (converged !== r.conv)        mismatch("converged", r.conv, converged);
                    if (last_of_run !== r.last)      mismatch("last_of_run", r.last,
                                                               last_of_run);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (kmce_pkg::cfg_idx_t'(cfg_index))
                    kmce_pkg::CFG_INIT0: seed_idx[0] = int'(cfg_data[7:0]);
                    kmce_pkg::CFG_INIT1: seed_idx[1] = int'(cfg_data[7:0]);
                    kmce_pkg::CFG_INIT2: seed_idx[2] = int'(cfg_data[7:0]);
                    kmce_pkg::CFG_LIMIT: pass_limit = int'(cfg_data);
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                case (kmce_pkg::cmd_t'(cmd))
                    kmce_pkg::CMD_CLEAR:
                    begin
                        npts = 0;
                        for (int i = 0; i < STORE_DEPTH; i++)
                            owner[i] = '0;
                    end
                    kmce_pkg::CMD_LOAD:
                    begin
                        if (npts < STORE_DEPTH)
                        begin
                            pts[npts][0] = coord_a;
                            pts[npts][1] = coord_b;
                            pts[npts][2] = coord_c;
                            pts[npts][3] = coord_d;
                            npts++;
                        end
                    end
                    kmce_pkg::CMD_QUERY:
                    begin
                        r.cid = (query_index < npts) ? owner[query_index] : 2'd0;
                        r.members = '0;
                        for (int d = 0; d < kmce_pkg::NUM_DIMS; d++)
                            r.ctr[d] = '0;
                        r.passes = '0;
                        r.conv = 1'b0;
                        r.last = 1'b1;
                        result_fifo.push_back(r);
                        queries_done++;
                    end
                    default:
                        predict_run();
                endcase
            end
            pending = result_fifo.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         cmd;
    logic signed [15:0] coord_a;
    logic signed [15:0] coord_b;
    logic signed [15:0] coord_c;
    logic signed [15:0] coord_d;
    logic [7:0]         query_index;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         cluster_id;
    logic [8:0]         member_count;
    logic signed [15:0] center_a;
    logic signed [15:0] center_b;
    logic signed [15:0] center_c;
    logic signed [15:0] center_d;
    logic [15:0]        passes_used;
    logic               converged;
    logic               last_of_run;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    int fail_count;
    int pending;
    int runs_done;
    int queries_done;
    int unconverged_runs;

    // Idle percentages for the current phase, sender side and receiver side
    int send_idle_pct;
    int recv_stall_pct;
    int items_sent;
    int phase_sel;

    // Cluster seeds for well-formed data sets, so runs actually converge
    logic signed [15:0] blob [kmce_pkg::NUM_CLUST][kmce_pkg::NUM_DIMS];

    kmeans_cluster_engine_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .coord_a      (coord_a),
        .coord_b      (coord_b),
        .coord_c      (coord_c),
        .coord_d      (coord_d),
        .query_index  (query_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cluster_id   (cluster_id),
        .member_count (member_count),
        .center_a     (center_a),
        .center_b     (center_b),
        .center_c     (center_c),
        .center_d     (center_d),
        .passes_used  (passes_used),
        .converged    (converged),
        .last_of_run  (last_of_run),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    kmce_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .coord_a          (coord_a),
        .coord_b          (coord_b),
        .coord_c          (coord_c),
        .coord_d          (coord_d),
        .query_index      (query_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .cluster_id       (cluster_id),
        .member_count     (member_count),
        .center_a         (center_a),
        .center_b         (center_b),
        .center_c         (center_c),
        .center_d         (center_d),
        .passes_used      (passes_used),
        .converged        (converged),
        .last_of_run      (last_of_run),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .pending          (pending),
        .runs_done        (runs_done),
        .queries_done     (queries_done),
        .unconverged_runs (unconverged_runs)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: stall at random per phase, change only on the falling edge
    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Hang guard, well above the slowest correct run
    initial
    begin
        #40ms;
        $display("** kmeans_cluster_engine_core: FAILED **");
        $finish;
    end

    // Drive one command transaction and hold it until the block takes it.
    task automatic send_cmd(kmce_pkg::cmd_t c, logic [15:0] a, logic [15:0] b,
                            logic [15:0] cc, logic [15:0] dd, logic [7:0] q);
        @(negedge clk);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid = 1'b1;
        cmd = c;
        coord_a = a;
        coord_b = b;
        coord_c = cc;
        coord_d = dd;
        query_index = q;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic send_noise(kmce_pkg::cmd_t c);
        send_cmd(c, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 8'($urandom));
    endtask

    task automatic load_pt(logic [15:0] a, logic [15:0] b, logic [15:0] cc, logic [15:0] dd);
        send_cmd(kmce_pkg::CMD_LOAD, a, b, cc, dd, 8'($urandom));
    endtask

    // Load a point near one of the blob seeds; a few are anywhere in range.
    task automatic load_blob_pt();
        int k;
        logic [15:0] v [kmce_pkg::NUM_DIMS];
        k = $urandom_range(0, kmce_pkg::NUM_CLUST - 1);
        for (int d = 0; d < kmce_pkg::NUM_DIMS; d++)
            v[d] = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                   : blob[k][d] + 16'($signed($urandom_range(0, 400)) - 200);
        load_pt(v[0], v[1], v[2], v[3]);
    endtask

    // Drain every expected result, then give the block time to finish silent work.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(kmce_pkg::cfg_idx_t idx, logic [15:0] val);
        settle();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_phase(int sel);
        case (sel % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
        endcase
    endtask

    initial
    begin
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = kmce_pkg::CMD_CLEAR;
        coord_a = '0;
        coord_b = '0;
        coord_c = '0;
        coord_d = '0;
        query_index = '0;
        cfg_valid = 1'b0;
        cfg_index = kmce_pkg::CFG_INIT0;
        cfg_data = '0;
        out_stall = 1'b0;
        items_sent = 0;
        phase_sel = 0;
        set_phase(0);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty store run and query, then extreme coordinates
        send_noise(kmce_pkg::CMD_RUN);
        send_cmd(kmce_pkg::CMD_QUERY, '0, '0, '0, '0, 8'd0);
        load_pt(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        load_pt(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        load_pt(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        load_pt(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        load_pt(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        load_pt(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);
        send_noise(kmce_pkg::CMD_RUN);
        for (int i = 0; i < 6; i++)
            send_cmd(kmce_pkg::CMD_QUERY, '0, '0, '0, '0, 8'(i));
        send_cmd(kmce_pkg::CMD_QUERY, '0, '0, '0, '0, 8'd255);

        // Seeds out of range give zero centers; a zero limit acts as one pass
        write_reg(kmce_pkg::CFG_INIT0, 16'd255);
        write_reg(kmce_pkg::CFG_INIT1, 16'd5);
        write_reg(kmce_pkg::CFG_INIT2, 16'd6);
        write_reg(kmce_pkg::CFG_LIMIT, 16'd0);
        send_noise(kmce_pkg::CMD_RUN);
        write_reg(kmce_pkg::CFG_LIMIT, 16'd65535);
        write_reg(kmce_pkg::CFG_INIT0, 16'd0);
        write_reg(kmce_pkg::CFG_INIT1, 16'd0);
        write_reg(kmce_pkg::CFG_INIT2, 16'd0);
        send_noise(kmce_pkg::CMD_RUN);
        send_noise(kmce_pkg::CMD_CLEAR);
        send_cmd(kmce_pkg::CMD_QUERY, '0, '0, '0, '0, 8'd1);
        send_noise(kmce_pkg::CMD_RUN);

        // Full store: the 257th point and beyond are dropped
        write_reg(kmce_pkg::CFG_LIMIT, 16'd2);
        write_reg(kmce_pkg::CFG_INIT0, 16'd0);
        write_reg(kmce_pkg::CFG_INIT1, 16'd128);
        write_reg(kmce_pkg::CFG_INIT2, 16'd255);
        set_phase(3);
        for (int i = 0; i < 258; i++)
            send_noise(kmce_pkg::CMD_LOAD);
        send_noise(kmce_pkg::CMD_RUN);
        send_cmd(kmce_pkg::CMD_QUERY, '0, '0, '0, '0, 8'd255);

        // Random data sets: configure, clear, load, run, read back
        while (items_sent < 470)
        begin
            phase_sel++;
            set_phase(phase_sel);
            for (int k = 0; k < kmce_pkg::NUM_CLUST; k++)
                for (int d = 0; d < kmce_pkg::NUM_DIMS; d++)
                    blob[k][d] = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                 : 16'($signed($urandom_range(0, 40000)) - 20000);
            n = $urandom_range(1, 14);
            write_reg(kmce_pkg::CFG_INIT0, 16'($urandom_range(0, n + 1)));
            write_reg(kmce_pkg::CFG_INIT1, 16'($urandom_range(0, n + 1)));
            write_reg(kmce_pkg::CFG_INIT2, $urandom_range(0, 9) == 0 ? 16'($urandom)
                                 : 16'($urandom_range(0, n + 1)));
            case ($urandom_range(0, 4))
                0:       write_reg(kmce_pkg::CFG_LIMIT, 16'($urandom_range(0, 3)));
                1:       write_reg(kmce_pkg::CFG_LIMIT, 16'd65535);
                default: write_reg(kmce_pkg::CFG_LIMIT, 16'($urandom_range(4, 40)));
            endcase
            send_noise(kmce_pkg::CMD_CLEAR);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_cmd(kmce_pkg::CMD_QUERY, '0, '0, '0, '0,
                             8'($urandom_range(0, n + 2)));
                else
                    load_blob_pt();
            end
            send_noise(kmce_pkg::CMD_RUN);
            repeat ($urandom_range(1, 4))
                send_cmd(kmce_pkg::CMD_QUERY, '0, '0, '0, '0, $urandom_range(0, 9) == 0 ?
                         8'($urandom) : 8'($urandom_range(0, n)));
            if ($urandom_range(0, 3) == 0)
                send_noise(kmce_pkg::CMD_RUN);
        end

        // Wait out the last results and any silent tail work
        settle();
        repeat (50) @(posedge clk);
        $display("Covered %0d transactions: %0d runs (%0d stopped at the limit), %0d reads.",
                 items_sent, runs_done, unconverged_runs, queries_done);
        if (fail_count == 0 && pending == 0)
            $display("** kmeans_cluster_engine_core: PASSED **");
        else
            $display("** kmeans_cluster_engine_core: FAILED **");
        $finish;
    end

endmodule
